// ===== src/deq_pkg.sv =====
package deq_pkg;

    localparam int KIND_W  = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_READ       = 3'd4
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_MISS  = 2'd3
    } status_t;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_READ
    } ctrl_state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        status_t            status;
        logic [FILL_W-1:0]  fill_level;
    } rsp_t;

endpackage

// ===== src/deq_ifs.sv =====
interface deq_req_if
    import deq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [VALUE_W-1:0]        value;
    logic signed [POS_W-1:0]   position;

    modport source (output valid, kind, value, position, input ready);
    modport sink   (input valid, kind, value, position, output ready);
endinterface

interface deq_rsp_if
    import deq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   read_value;
    logic [STAT_W-1:0]    status;
    logic [FILL_W-1:0]    fill_level;

    modport source (output valid, read_value, status, fill_level, input ready);
    modport sink   (input valid, read_value, status, fill_level, output ready);
endinterface

// ===== src/deq_store.sv =====
module deq_store #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    localparam int IW        = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [IW-1:0]         waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  re,
    input  logic [IW-1:0]         raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/deq_rsp_fifo.sv =====
module deq_rsp_fifo
    import deq_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rsp_t            push_data,
    output logic            room,
    deq_rsp_if.source       rsp
);

    rsp_t       slot_reg [2];
    logic       head_reg, head_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;
    logic       tail;

    assign pop  = rsp.valid && rsp.ready;
    assign tail = head_reg ^ cnt_reg[0];
    assign room = (cnt_reg != 2'd2);

    assign rsp.valid      = (cnt_reg != 2'd0);
    assign rsp.read_value = slot_reg[head_reg].read_value;
    assign rsp.status     = slot_reg[head_reg].status;
    assign rsp.fill_level = slot_reg[head_reg].fill_level;

    always_comb
    begin
        head_next = head_reg ^ pop;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail] <= push_data;
        end
    end

endmodule

// ===== src/deq_ctrl.sv =====
module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    localparam int IW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    deq_req_if.sink               req,
    output logic                  mem_we,
    output logic [IW-1:0]         mem_waddr,
    output logic [DATA_WIDTH-1:0] mem_wdata,
    output logic                  mem_re,
    output logic [IW-1:0]         mem_raddr,
    input  logic [DATA_WIDTH-1:0] mem_rdata,
    output logic                  rsp_push,
    output rsp_t                  rsp_data,
    input  logic                  rsp_room
);

    localparam int CMPW = (CW > POS_W - 1) ? CW : POS_W - 1;
    localparam logic [IW:0] DEPTH_W = (IW + 1)'(DEPTH);

    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a,
                                               input logic [IW-1:0] b);
        logic [IW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[IW-1:0];
    endfunction

    ctrl_state_t     state_reg, state_next;
    logic [IW-1:0]   front_reg, front_next;
    logic [CW-1:0]   count_reg, count_next;

    kind_t           kind;
    logic            full;
    logic            empty;
    logic            miss;
    logic [CMPW-1:0] posx;
    logic [IW-1:0]   dec_front;
    logic [IW-1:0]   inc_front;
    logic [IW-1:0]   back_addr;

    assign kind      = kind_t'(req.kind);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign posx      = CMPW'(req.position[POS_W-2:0]);
    assign miss      = req.position[POS_W-1] || (posx >= CMPW'(count_reg));
    assign dec_front = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - 1'b1;
    assign inc_front = ring_add(front_reg, IW'(1));
    // back slot only used when not full, so the count fits the index
    assign back_addr = ring_add(front_reg, IW'(count_reg));

    always_comb
    begin
        state_next          = state_reg;
        front_next          = front_reg;
        count_next          = count_reg;
        req.ready           = 1'b0;
        mem_we              = 1'b0;
        mem_waddr           = back_addr;
        mem_wdata           = DATA_WIDTH'(req.value);
        mem_re              = 1'b0;
        mem_raddr           = ring_add(front_reg, posx[IW-1:0]);
        rsp_push            = 1'b0;
        rsp_data.read_value = '0;
        rsp_data.status     = STAT_OK;

        unique case (state_reg)
            CTRL_IDLE:
            begin
                req.ready = rsp_room;
                if (req.valid && rsp_room)
                begin
                    rsp_push = 1'b1;
                    unique case (kind)
                        KIND_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                rsp_data.status = STAT_FULL;
                            end
                            else
                            begin
                                front_next = dec_front;
                                count_next = count_reg + 1'b1;
                                mem_we     = 1'b1;
                                mem_waddr  = dec_front;
                            end
                        end
                        KIND_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                rsp_data.status = STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                mem_we     = 1'b1;
                            end
                        end
                        KIND_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                rsp_data.status = STAT_EMPTY;
                            end
                            else
                            begin
                                front_next = inc_front;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        KIND_POP_BACK:
                        begin
                            if (empty)
                            begin
                                rsp_data.status = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        KIND_READ:
                        begin
                            if (miss)
                            begin
                                rsp_data.status = STAT_MISS;
                            end
                            else
                            begin
                                // answer once the store returns the word
                                rsp_push   = 1'b0;
                                mem_re     = 1'b1;
                                state_next = CTRL_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            CTRL_READ:
            begin
                rsp_push            = 1'b1;
                rsp_data.read_value = VALUE_W'(mem_rdata);
                state_next          = CTRL_IDLE;
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase

        rsp_data.fill_level = FILL_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/double_ended_queue_unit.sv =====
// Bounded double-ended queue over a ring of DEPTH words of DATA_WIDTH bits.
// Request channel (req): kind selects push front, push back, pop front,
// pop back or read at position; value is the word to push; position is a
// signed index from the front for reads. Response channel (rsp): exactly one
// transaction per request, in order, with read_value, status and the fill
// level after the request.
// Timing: pushes, pops, refused requests and read misses enter the output
// queue when accepted; a read hit first reads the ring store through its
// synchronous read port and answers from CTRL_READ, when req.ready is low.
// Throughput: one request per cycle when ready; read hits hold req.ready low.
// Responses wait in a two-entry output queue, so new requests are taken
// while an earlier response is still pending; req.ready also drops while
// that queue is full, and rsp.valid holds until the receiver takes it.
// Reset (rst_n low, asynchronous) empties the queue: front slot and fill
// count go to zero and pending responses are dropped. Store contents are
// not cleared; only slots written by a push are ever read back.
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    localparam int IW = $clog2(DEPTH);

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [IW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic                  rsp_push;
    rsp_t                  rsp_data;
    logic                  rsp_room;

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .rsp_push  (rsp_push),
        .rsp_data  (rsp_data),
        .rsp_room  (rsp_room)
    );

    deq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    deq_rsp_fifo u_rsp_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rsp_push),
        .push_data (rsp_data),
        .room      (rsp_room),
        .rsp       (rsp)
    );

endmodule
